// ===== design/mkd_pkg.sv =====
`default_nettype none

package mkd_pkg;

	localparam int CFG_INDEX_W = 8;
	localparam int LIMIT_W     = 16;
	localparam int CODE_W      = 6;

	localparam logic [CFG_INDEX_W-1:0] REG_DOT_LIMIT        = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DASH_LIMIT       = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SYMBOL_GAP_LIMIT = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_LETTER_GAP_LIMIT = 8'd3;

	localparam logic [LIMIT_W-1:0] DOT_LIMIT_RST        = 16'd200;
	localparam logic [LIMIT_W-1:0] DASH_LIMIT_RST       = 16'd1000;
	localparam logic [LIMIT_W-1:0] SYMBOL_GAP_LIMIT_RST = 16'd200;
	localparam logic [LIMIT_W-1:0] LETTER_GAP_LIMIT_RST = 16'd500;

	localparam logic [1:0] KIND_CHAR  = 2'd0;
	localparam logic [1:0] KIND_SPACE = 2'd1;
	localparam logic [1:0] KIND_BACK  = 2'd2;

	localparam logic [6:0] CHAR_UNKNOWN = 7'h21;
	localparam logic [6:0] CHAR_SPACE   = 7'h20;
	localparam logic [6:0] CHAR_NONE    = 7'h00;

	// The newest symbol sits in bit 0 of bits; a dash is a one.
	function automatic logic [6:0] decode_char(input logic [2:0] len,
			input logic [CODE_W-1:0] bits);
		logic [CODE_W-1:0] masked;
		logic [6:0]        ch;
		masked = bits & ~(6'h3f << len);
		unique case ({len, masked})
			{3'd2, 6'd1}:  ch = 7'h41;
			{3'd4, 6'd8}:  ch = 7'h42;
			{3'd4, 6'd10}: ch = 7'h43;
			{3'd3, 6'd4}:  ch = 7'h44;
			{3'd1, 6'd0}:  ch = 7'h45;
			{3'd4, 6'd2}:  ch = 7'h46;
			{3'd3, 6'd6}:  ch = 7'h47;
			{3'd4, 6'd0}:  ch = 7'h48;
			{3'd2, 6'd0}:  ch = 7'h49;
			{3'd4, 6'd7}:  ch = 7'h4a;
			{3'd3, 6'd5}:  ch = 7'h4b;
			{3'd4, 6'd4}:  ch = 7'h4c;
			{3'd2, 6'd3}:  ch = 7'h4d;
			{3'd2, 6'd2}:  ch = 7'h4e;
			{3'd3, 6'd7}:  ch = 7'h4f;
			{3'd4, 6'd6}:  ch = 7'h50;
			{3'd4, 6'd13}: ch = 7'h51;
			{3'd3, 6'd2}:  ch = 7'h52;
			{3'd3, 6'd0}:  ch = 7'h53;
			{3'd1, 6'd1}:  ch = 7'h54;
			{3'd3, 6'd1}:  ch = 7'h55;
			{3'd4, 6'd1}:  ch = 7'h56;
			{3'd3, 6'd3}:  ch = 7'h57;
			{3'd4, 6'd9}:  ch = 7'h58;
			{3'd4, 6'd11}: ch = 7'h59;
			{3'd4, 6'd12}: ch = 7'h5a;
			{3'd6, 6'd21}: ch = 7'h2e;
			{3'd5, 6'd15}: ch = 7'h31;
			{3'd5, 6'd7}:  ch = 7'h32;
			{3'd5, 6'd3}:  ch = 7'h33;
			{3'd5, 6'd1}:  ch = 7'h34;
			{3'd5, 6'd0}:  ch = 7'h35;
			{3'd5, 6'd16}: ch = 7'h36;
			{3'd5, 6'd24}: ch = 7'h37;
			{3'd5, 6'd28}: ch = 7'h38;
			{3'd5, 6'd30}: ch = 7'h39;
			{3'd5, 6'd31}: ch = 7'h30;
			default:       ch = CHAR_UNKNOWN;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

// ===== design/morse_key_decoder.sv =====
// Morse key decoder.
// Input channel (in_valid/in_ready): one beat is a key event (op = 0) with
// key_released and duration_ms, or a silence timeout (op = 1). Presses are
// classed as dot, dash or backspace, gaps as symbol, letter or word gap.
// Output channel (out_valid/out_ready): decoded characters, word spaces and
// backspace markers; last marks the final result of one input beat.
// Configuration channel (cfg_valid/cfg_ready): cfg_index selects one of the
// four 16-bit limits, cfg_data is the value. cfg_ready is always high and
// writes to unknown indexes are dropped. Write only while the block is idle.
// An accepted input beat is held in the input register; its first result is
// loaded into the output register once that register is free.
// Throughput: one input beat per cycle while the output is free; a word gap
// that closes a letter produces two results and holds the output for both.
// When the receiver stalls, the output register holds its result; the input
// register still drains beats that produce no result and then stalls too.
// Reset clears both registers and the symbol count and restores the default
// limits; the key is taken as released.
`default_nettype none

module morse_key_decoder import mkd_pkg::*; #(
	parameter int SYMBOL_DEPTH = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic                   op,
	input  wire logic                   key_released,
	input  wire logic [15:0]            duration_ms,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [1:0]                  kind,
	output logic [6:0]                  char_code,
	output logic                        last,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [LIMIT_W-1:0]     cfg_data
);

	localparam int CNT_W = $clog2(SYMBOL_DEPTH + 1);

	typedef enum logic [2:0] {
		TOK_DOT,
		TOK_DASH,
		TOK_BACK,
		TOK_SGAP,
		TOK_LGAP,
		TOK_WGAP
	} tok_t;

	logic [LIMIT_W-1:0] dot_limit_q;
	logic [LIMIT_W-1:0] dash_limit_q;
	logic [LIMIT_W-1:0] symbol_gap_limit_q;
	logic [LIMIT_W-1:0] letter_gap_limit_q;

	logic               valid_s1;
	logic               op_s1;
	logic               released_s1;
	logic [15:0]        duration_s1;

	logic [CNT_W-1:0]   count_q;
	logic [CODE_W-1:0]  code_q;
	logic               last_release_q;

	logic               space_pend_q;

	tok_t               tok;
	logic [CNT_W-1:0]   count_base;
	logic               has_result;
	logic [1:0]         res_kind;
	logic [6:0]         res_char;
	logic               res_last;
	logic               res_space;
	logic               buf_free;
	logic               advance;

	assign cfg_ready = 1'b1;

	always_comb begin
		if (op_s1) begin
			tok = last_release_q ? TOK_WGAP : TOK_BACK;
		end else if (released_s1) begin
			if (duration_s1 <= dot_limit_q) tok = TOK_DOT;
			else if (duration_s1 <= dash_limit_q) tok = TOK_DASH;
			else tok = TOK_BACK;
		end else begin
			if (duration_s1 <= symbol_gap_limit_q) tok = TOK_SGAP;
			else if (duration_s1 <= letter_gap_limit_q) tok = TOK_LGAP;
			else tok = TOK_WGAP;
		end
	end

	// A full store is emptied before the beat is handled.
	assign count_base = (count_q >= CNT_W'(SYMBOL_DEPTH)) ? '0 : count_q;

	always_comb begin
		has_result = 1'b0;
		res_kind   = KIND_CHAR;
		res_char   = CHAR_UNKNOWN;
		res_last   = 1'b1;
		res_space  = 1'b0;
		unique case (tok)
			TOK_LGAP, TOK_WGAP: begin
				has_result = (count_base != '0);
				if (count_base <= CNT_W'(CODE_W)) begin
					res_char = decode_char(count_base[2:0], code_q);
				end
				res_last  = (tok == TOK_LGAP);
				res_space = (tok == TOK_WGAP);
			end
			TOK_BACK: begin
				has_result = 1'b1;
				res_kind   = KIND_BACK;
				res_char   = CHAR_NONE;
			end
			default: begin
			end
		endcase
	end

	assign buf_free = !out_valid || (out_ready && !space_pend_q);
	assign advance  = valid_s1 && (!has_result || buf_free);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_limit_q        <= DOT_LIMIT_RST;
			dash_limit_q       <= DASH_LIMIT_RST;
			symbol_gap_limit_q <= SYMBOL_GAP_LIMIT_RST;
			letter_gap_limit_q <= LETTER_GAP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_DOT_LIMIT) dot_limit_q <= cfg_data;
			if (cfg_index == REG_DASH_LIMIT) dash_limit_q <= cfg_data;
			if (cfg_index == REG_SYMBOL_GAP_LIMIT) symbol_gap_limit_q <= cfg_data;
			if (cfg_index == REG_LETTER_GAP_LIMIT) letter_gap_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1       <= op;
			released_s1 <= key_released;
			duration_s1 <= duration_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			last_release_q <= 1'b1;
		end else if (advance) begin
			if (!op_s1) begin
				last_release_q <= released_s1;
			end
			unique case (tok)
				TOK_DOT, TOK_DASH:  count_q <= count_base + CNT_W'(1);
				TOK_LGAP, TOK_WGAP: count_q <= '0;
				default:            count_q <= count_base;
			endcase
		end
	end

	// Only the newest few symbols can form a known code, so a short shift
	// register stands in for the store.
	always_ff @(posedge clk) begin
		if (advance && (tok == TOK_DOT || tok == TOK_DASH)) begin
			code_q <= {code_q[CODE_W-2:0], tok == TOK_DASH};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid    <= 1'b0;
			space_pend_q <= 1'b0;
		end else if (advance && has_result) begin
			out_valid    <= 1'b1;
			space_pend_q <= res_space;
		end else if (out_valid && out_ready) begin
			if (space_pend_q) begin
				space_pend_q <= 1'b0;
			end else begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			kind      <= res_kind;
			char_code <= res_char;
			last      <= res_last;
		end else if (out_valid && out_ready && space_pend_q) begin
			kind      <= KIND_SPACE;
			char_code <= CHAR_SPACE;
			last      <= 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== design/mkd_checker.sv =====
`default_nettype none

module mkd_checker import mkd_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [1:0]             kind,
	input wire logic [6:0]             char_code,
	input wire logic                   last
);

	// A character that is not the last result of its beat is followed by a space.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && kind == KIND_CHAR && !last
		|=> out_valid && kind == KIND_SPACE && last)
		else $error("word space did not follow its character");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_SPACE |-> char_code == CHAR_SPACE && last)
		else $error("malformed space beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BACK |-> char_code == CHAR_NONE && last)
		else $error("malformed backspace beat");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready
		|=> out_valid && $stable(kind) && $stable(char_code) && $stable(last))
		else $error("output beat changed while stalled");

endmodule

bind morse_key_decoder mkd_checker u_mkd_checker (.*);

`default_nettype wire
